// ===== rtl/core/qhr_pkg.sv =====
package qhr_pkg;

    // Field widths of one record and of one result
    localparam int AGE_W       = 5;
    localparam int SMALL_W     = 16;
    localparam int LARGE_W     = 32;
    localparam int SMALL_TOT_W = 21;
    localparam int LARGE_TOT_W = 37;
    localparam int HELD_W      = 6;
    localparam int PCT_W       = 7;
    localparam int PCT_SCALE   = 100;

    // Operation codes
    typedef enum logic [1:0] {
        FUNC_PUSH  = 2'd0,
        FUNC_GET   = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_AGG   = 2'd3
    } func_t;

    // One stored record
    typedef struct packed {
        logic [LARGE_W-1:0] dropped;
        logic [LARGE_W-1:0] underrun;
        logic [SMALL_W-1:0] voice;
        logic [SMALL_W-1:0] decode_fail;
        logic [SMALL_W-1:0] decode_ok;
    } rec_t;

    // Controller to datapath
    typedef struct packed {
        logic take;        // request accepted, capture payload
        logic push;        // write record at head
        logic clear;       // empty the ring
        logic get_rd;      // look up record by age
        logic walk_start;  // clear totals and walk index
        logic walk_rd;     // read next held slot for the totals
        logic mul;         // set up the percentage division
        logic div_step;    // one quotient bit
        logic load_out;    // load the result register
    } qhr_cmd_t;

    // Datapath to controller
    typedef struct packed {
        func_t func;
        logic  walk_more;
        logic  div_last;
        logic  out_free;
    } qhr_stat_t;

endpackage

// ===== rtl/core/qhr_ctrl.sv =====
module qhr_ctrl
    import qhr_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  qhr_stat_t st,
    output qhr_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_WALK,
        ST_MUL,
        ST_DIV,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.take = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (st.func)
                    FUNC_PUSH: begin
                        cmd.push   = 1'b1;
                        state_next = ST_FINISH;
                    end
                    FUNC_GET: begin
                        cmd.get_rd = 1'b1;
                        state_next = ST_FINISH;
                    end
                    FUNC_CLEAR: begin
                        cmd.clear  = 1'b1;
                        state_next = ST_FINISH;
                    end
                    default: begin
                        cmd.walk_start = 1'b1;
                        state_next     = ST_WALK;
                    end
                endcase
            end
            ST_WALK: begin
                cmd.walk_rd = st.walk_more;
                if (!st.walk_more) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (st.div_last) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                cmd.load_out = st.out_free;
                if (st.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    // Only one request in flight
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("qhr_ctrl: second request taken while busy");

    // Walk ends only once all held slots are read
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL) |-> $past(!st.walk_more))
        else $error("qhr_ctrl: totals used before walk completed");

    // A result is loaded only when the output side can take it
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> st.out_free)
        else $error("qhr_ctrl: result loaded over pending result");

endmodule

// ===== rtl/core/qhr_dp.sv =====
module qhr_dp
    import qhr_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  qhr_cmd_t               cmd,
    output qhr_stat_t              st,
    input  func_t                  in_func,
    input  logic [AGE_W-1:0]       in_age_index,
    input  rec_t                   in_rec,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   out_found,
    output logic [HELD_W-1:0]      out_held_count,
    output logic [SMALL_TOT_W-1:0] out_decode_ok,
    output logic [SMALL_TOT_W-1:0] out_decode_fail,
    output logic [SMALL_TOT_W-1:0] out_voice,
    output logic [LARGE_TOT_W-1:0] out_underrun,
    output logic [LARGE_TOT_W-1:0] out_dropped,
    output logic [PCT_W-1:0]       out_ok_percent
);

    localparam int PW    = $clog2(CAPACITY);
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int AW    = (CW > AGE_W) ? CW : AGE_W;
    localparam int OKW   = SMALL_W + CW;
    localparam int BIGW  = LARGE_W + CW;
    localparam int NUMW  = OKW + PCT_W;
    localparam int DENW  = OKW + 1;
    localparam int DSHW  = NUMW + 1;
    localparam int STEPW = $clog2(PCT_W);

    // Request payload
    func_t            func_reg;
    logic [AGE_W-1:0] age_reg;
    rec_t             wrec_reg;

    // Ring pointers
    logic [PW-1:0] head_reg;
    logic [CW-1:0] count_reg;

    // Record memory and read port
    rec_t          mem [CAPACITY];
    rec_t          rd_reg;
    logic          rd_en;
    logic [PW-1:0] rd_addr;

    // Lookup and walk
    logic          hit_reg;
    logic [CW-1:0] walk_idx_reg;
    logic          acc_vld_reg;

    // Totals
    logic [OKW-1:0]  acc_ok_reg;
    logic [OKW-1:0]  acc_fail_reg;
    logic [OKW-1:0]  acc_voice_reg;
    logic [BIGW-1:0] acc_under_reg;
    logic [BIGW-1:0] acc_drop_reg;

    // Percentage divider
    logic [NUMW-1:0]  rem_reg;
    logic [DENW-1:0]  den_reg;
    logic [PCT_W-1:0] quot_reg;
    logic [STEPW-1:0] step_reg;
    logic [DSHW-1:0]  den_sh;

    // Result register
    logic                   m_valid_reg;
    logic                   found_reg;
    logic [HELD_W-1:0]      held_reg;
    logic [SMALL_TOT_W-1:0] ok_reg;
    logic [SMALL_TOT_W-1:0] fail_reg;
    logic [SMALL_TOT_W-1:0] voice_reg;
    logic [LARGE_TOT_W-1:0] under_reg;
    logic [LARGE_TOT_W-1:0] drop_reg;
    logic [PCT_W-1:0]       pct_reg;

    logic          full;
    logic [AW-1:0] age_ext;
    logic          hit;
    logic [PW:0]   wrap_sum;
    logic [PW-1:0] wrap_slot;
    logic [PW-1:0] get_slot;
    logic [PW-1:0] head_inc;

    // Slot of a record by age: oldest is slot 0 until the ring fills, then head
    always_comb begin
        full      = (count_reg == CW'(CAPACITY));
        age_ext   = AW'(age_reg);
        hit       = (age_ext < AW'(count_reg));
        wrap_sum  = (PW+1)'(head_reg) + (PW+1)'(age_ext[PW-1:0]);
        wrap_slot = (wrap_sum >= (PW+1)'(CAPACITY)) ?
                    PW'(wrap_sum - (PW+1)'(CAPACITY)) : PW'(wrap_sum);
        get_slot  = full ? wrap_slot : age_ext[PW-1:0];
        head_inc  = (head_reg == PW'(CAPACITY - 1)) ? '0 : head_reg + 1'b1;
        rd_en     = (cmd.get_rd && hit) || cmd.walk_rd;
        rd_addr   = cmd.walk_rd ? walk_idx_reg[PW-1:0] : get_slot;
        den_sh    = DSHW'(den_reg) << step_reg;
    end

    // Status back to the controller
    always_comb begin
        st.func      = func_reg;
        st.walk_more = (walk_idx_reg < count_reg);
        st.div_last  = (step_reg == '0);
        st.out_free  = !m_valid_reg || m_ready;
    end

    // Payload capture
    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            func_reg <= in_func;
            age_reg  <= in_age_index;
            wrec_reg <= in_rec;
        end
    end

    // Head and held count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
        end else if (cmd.clear) begin
            head_reg  <= '0;
            count_reg <= '0;
        end else if (cmd.push) begin
            head_reg <= head_inc;
            if (!full) begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    // Record memory, one write and one registered read
    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            mem[head_reg] <= wrec_reg;
        end
        if (rd_en) begin
            rd_reg <= mem[rd_addr];
        end
    end

    // Walk control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_vld_reg <= 1'b0;
        end else begin
            acc_vld_reg <= cmd.walk_rd;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.get_rd) begin
            hit_reg <= hit;
        end
        if (cmd.walk_start) begin
            walk_idx_reg <= '0;
        end else if (cmd.walk_rd) begin
            walk_idx_reg <= walk_idx_reg + 1'b1;
        end
    end

    // Running totals over the walked slots
    always_ff @(posedge aclk) begin
        if (cmd.walk_start) begin
            acc_ok_reg    <= '0;
            acc_fail_reg  <= '0;
            acc_voice_reg <= '0;
            acc_under_reg <= '0;
            acc_drop_reg  <= '0;
        end else if (acc_vld_reg) begin
            acc_ok_reg    <= acc_ok_reg + OKW'(rd_reg.decode_ok);
            acc_fail_reg  <= acc_fail_reg + OKW'(rd_reg.decode_fail);
            acc_voice_reg <= acc_voice_reg + OKW'(rd_reg.voice);
            acc_under_reg <= acc_under_reg + BIGW'(rd_reg.underrun);
            acc_drop_reg  <= acc_drop_reg + BIGW'(rd_reg.dropped);
        end
    end

    // Restoring division, one quotient bit per cycle from the top
    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            rem_reg  <= NUMW'(acc_ok_reg) * NUMW'(PCT_SCALE);
            den_reg  <= DENW'(acc_ok_reg) + DENW'(acc_fail_reg);
            quot_reg <= '0;
            step_reg <= STEPW'(PCT_W - 1);
        end else if (cmd.div_step) begin
            if (DSHW'(rem_reg) >= den_sh) begin
                rem_reg            <= NUMW'(DSHW'(rem_reg) - den_sh);
                quot_reg[step_reg] <= 1'b1;
            end
            step_reg <= step_reg - 1'b1;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            found_reg <= 1'b1;
            held_reg  <= HELD_W'(count_reg);
            ok_reg    <= '0;
            fail_reg  <= '0;
            voice_reg <= '0;
            under_reg <= '0;
            drop_reg  <= '0;
            pct_reg   <= '0;
            case (func_reg)
                FUNC_GET: begin
                    found_reg <= hit_reg;
                    if (hit_reg) begin
                        ok_reg    <= SMALL_TOT_W'(rd_reg.decode_ok);
                        fail_reg  <= SMALL_TOT_W'(rd_reg.decode_fail);
                        voice_reg <= SMALL_TOT_W'(rd_reg.voice);
                        under_reg <= LARGE_TOT_W'(rd_reg.underrun);
                        drop_reg  <= LARGE_TOT_W'(rd_reg.dropped);
                    end
                end
                FUNC_AGG: begin
                    ok_reg    <= SMALL_TOT_W'(acc_ok_reg);
                    fail_reg  <= SMALL_TOT_W'(acc_fail_reg);
                    voice_reg <= SMALL_TOT_W'(acc_voice_reg);
                    under_reg <= LARGE_TOT_W'(acc_under_reg);
                    drop_reg  <= LARGE_TOT_W'(acc_drop_reg);
                    // no decodes at all gives zero
                    pct_reg   <= (den_reg == '0) ? '0 : quot_reg;
                end
                default: begin
                    found_reg <= 1'b1;
                end
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign out_found       = found_reg;
    assign out_held_count  = held_reg;
    assign out_decode_ok   = ok_reg;
    assign out_decode_fail = fail_reg;
    assign out_voice       = voice_reg;
    assign out_underrun    = under_reg;
    assign out_dropped     = drop_reg;
    assign out_ok_percent  = pct_reg;

    // Held count never passes capacity
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("qhr_dp: held count above capacity");

    // Until full, the head sits just past the newest of slots 0..count-1
    assert property (@(posedge aclk) disable iff (!aresetn)
        !full |-> (CW'(head_reg) == count_reg))
        else $error("qhr_dp: head and count out of step");

    // Quotient fits in the percentage field
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_out && func_reg == FUNC_AGG && den_reg != '0) |=> pct_reg <= PCT_W'(PCT_SCALE))
        else $error("qhr_dp: percentage above scale");

endmodule

// ===== rtl/core/quality_history_ring_unit.sv =====
// Push, get and clear: decode the request, then load the result register.
// Aggregate: the totals walk reads one memory slot per cycle through the single
// read port, then a restoring division forms the seven-bit percentage.
// One request at a time; the next is taken while a result waits at m_tdata.
// Synchronous active-low reset empties the ring; record memory is not cleared.
module quality_history_ring_unit
    import qhr_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // age_index[4:0], in_decode_ok[20:5], in_decode_fail[36:21], in_voice[52:37],
    // in_underrun[84:53], in_dropped[116:85], zero pad [119:117]
    input  logic [119:0] s_tdata,
    // func[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // found[0], held_count[6:1], out_decode_ok[27:7], out_decode_fail[48:28],
    // out_voice[69:49], out_underrun[106:70], out_dropped[143:107],
    // ok_percent[150:144], zero pad [151]
    output logic [151:0] m_tdata
);

    qhr_cmd_t  cmd;
    qhr_stat_t st;
    rec_t      in_rec;

    logic                   found;
    logic [HELD_W-1:0]      held_count;
    logic [SMALL_TOT_W-1:0] out_decode_ok;
    logic [SMALL_TOT_W-1:0] out_decode_fail;
    logic [SMALL_TOT_W-1:0] out_voice;
    logic [LARGE_TOT_W-1:0] out_underrun;
    logic [LARGE_TOT_W-1:0] out_dropped;
    logic [PCT_W-1:0]       ok_percent;

    // Request unpacking
    assign in_rec.decode_ok   = s_tdata[20:5];
    assign in_rec.decode_fail = s_tdata[36:21];
    assign in_rec.voice       = s_tdata[52:37];
    assign in_rec.underrun    = s_tdata[84:53];
    assign in_rec.dropped     = s_tdata[116:85];

    qhr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    qhr_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .st              (st),
        .in_func         (func_t'(s_tuser)),
        .in_age_index    (s_tdata[4:0]),
        .in_rec          (in_rec),
        .m_valid         (m_tvalid),
        .m_ready         (m_tready),
        .out_found       (found),
        .out_held_count  (held_count),
        .out_decode_ok   (out_decode_ok),
        .out_decode_fail (out_decode_fail),
        .out_voice       (out_voice),
        .out_underrun    (out_underrun),
        .out_dropped     (out_dropped),
        .out_ok_percent  (ok_percent)
    );

    // Result packing
    assign m_tdata = {1'b0, ok_percent, out_dropped, out_underrun, out_voice,
                      out_decode_fail, out_decode_ok, held_count, found};

endmodule
